[rtl/bfla_pkg.sv]
// Shared types and constants for the block free list allocator.
// Depends on nothing; the allocator and the checker import it.
package bfla_pkg;

   // Pool geometry and the request limit.
   localparam int NUM_BLOCKS  = 1024;
   localparam int MAX_REQUEST = 64;

   // Field widths of the request and response channels.
   localparam int ID_W    = 10;
   localparam int COUNT_W = 7;
   localparam int TOTAL_W = 11;

   // Request opcodes.
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Response status codes.
   typedef enum logic [2:0] {
      ST_GRANTED = 3'd0,
      ST_INSUFF  = 3'd1,
      ST_INVALID = 3'd2,
      ST_DOUBLE  = 3'd3,
      ST_DONE    = 3'd4
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_ALLOC,
      S_FREE_CHK
   } state_type;

endpackage

[rtl/bfla_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the free stack and the free map; no package dependency.
module bfla_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds when not enabled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/block_free_list_allocator.sv]
// Block allocator: LIFO stack of free ids plus a one-bit-per-block free map.
// Allocate of n blocks: stack read, then response register, then one id per
// cycle (one stack read per cycle) while the response slot is free; next
// request taken after the last. Zero, insufficient and invalid requests:
// result in the cycle after the transfer. Free: map read, then map write
// and push unless rejected. Synchronous reset clears control; memory contents
// below a low-water mark stand for their reset values, so no clearing pass.
module block_free_list_allocator
   import bfla_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic [COUNT_W-1:0] req_count,
   input  logic [ID_W-1:0]    req_free_id,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [ID_W-1:0]    rsp_granted_id,
   output logic [2:0]         rsp_status,
   output logic               rsp_last,
   output logic [TOTAL_W-1:0] rsp_free_count
);

   localparam logic [TOTAL_W-1:0] NUM_TOTAL = TOTAL_W'(NUM_BLOCKS);
   localparam logic [TOTAL_W-1:0] TOP_ID    = TOTAL_W'(NUM_BLOCKS - 1);

   state_type          state_ff, state_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TOTAL_W-1:0] low_ff, low_in;
   logic [COUNT_W-1:0] remain_ff, remain_in;
   logic [ID_W-1:0]    fid_ff, fid_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [TOTAL_W-1:0] rsp_count_ff, rsp_count_in;

   logic               stk_we, stk_re;
   logic [ID_W-1:0]    stk_wr_addr, stk_wr_data, stk_rd_addr, stk_rd_data;
   logic               map_we, map_re, map_wr_data, map_rd_data;
   logic [ID_W-1:0]    map_wr_addr, map_rd_addr;

   logic               slot_free;
   logic               emit;
   status_type         emit_status;
   logic [ID_W-1:0]    emit_id;
   logic               emit_last;
   logic [TOTAL_W-1:0] pos;
   logic [TOTAL_W-1:0] pos_next;
   logic               pos_fresh;
   logic [ID_W-1:0]    got_id;
   logic [TOTAL_W-1:0] touch_sum;
   logic               id_free;

   // Stack of free ids, indexed by depth from the bottom.
   bfla_ram #(
      .WIDTH (ID_W),
      .DEPTH (NUM_BLOCKS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_re),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   // Free map, one bit per block id.
   bfla_ram #(
      .WIDTH (1),
      .DEPTH (NUM_BLOCKS)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (map_re),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   // A stack slot at or above the low-water mark has been pushed since reset;
   // a slot below it still holds its reset id. Ids are handed out from the
   // untouched region in increasing order, so an id whose sum with the mark
   // reaches the pool size has never been allocated and is still free.
   assign pos       = total_ff - TOTAL_W'(1);
   assign pos_next  = pos - TOTAL_W'(1);
   assign pos_fresh = (pos < low_ff);
   assign got_id    = pos_fresh ? ID_W'(TOP_ID - pos) : stk_rd_data;
   assign touch_sum = TOTAL_W'(fid_ff) + low_ff;
   assign id_free   = (touch_sum >= NUM_TOTAL) ? 1'b1 : map_rd_data;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Sequencer: next state, memory controls and the response register.
   always_comb begin
      state_in    = state_ff;
      total_in    = total_ff;
      low_in      = low_ff;
      remain_in   = remain_ff;
      fid_in      = fid_ff;
      emit        = 1'b0;
      emit_status = ST_DONE;
      emit_id     = '0;
      emit_last   = 1'b1;
      stk_we      = 1'b0;
      stk_wr_addr = total_ff[ID_W-1:0];
      stk_wr_data = fid_ff;
      stk_re      = 1'b0;
      stk_rd_addr = pos[ID_W-1:0];
      map_we      = 1'b0;
      map_wr_addr = fid_ff;
      map_wr_data = 1'b1;
      map_re      = 1'b0;
      map_rd_addr = req_free_id;
      req_ready   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = slot_free;
            if (req_valid && slot_free) begin
               if (req_cmd == CMD_ALLOC) begin
                  if (req_count == '0) begin
                     emit        = 1'b1;
                     emit_status = ST_DONE;
                  end else if (req_count > COUNT_W'(MAX_REQUEST) ||
                               TOTAL_W'(req_count) > total_ff) begin
                     emit        = 1'b1;
                     emit_status = ST_INSUFF;
                  end else begin
                     stk_re    = 1'b1;
                     stk_rd_addr = pos[ID_W-1:0];
                     remain_in = req_count;
                     state_in  = S_ALLOC;
                  end
               end else begin
                  if (TOTAL_W'(req_free_id) >= NUM_TOTAL) begin
                     emit        = 1'b1;
                     emit_status = ST_INVALID;
                  end else begin
                     map_re   = 1'b1;
                     fid_in   = req_free_id;
                     state_in = S_FREE_CHK;
                  end
               end
            end
         end

         S_ALLOC: begin
            // Pop one id per cycle while the response slot can take it.
            if (slot_free) begin
               total_in    = pos;
               if (pos_fresh) begin
                  low_in = pos;
               end
               map_we      = 1'b1;
               map_wr_addr = got_id;
               map_wr_data = 1'b0;
               emit        = 1'b1;
               emit_status = ST_GRANTED;
               emit_id     = got_id;
               emit_last   = (remain_ff == COUNT_W'(1));
               remain_in   = remain_ff - COUNT_W'(1);
               if (remain_ff == COUNT_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  stk_re      = 1'b1;
                  stk_rd_addr = pos_next[ID_W-1:0];
               end
            end
         end

         S_FREE_CHK: begin
            // Map bit is back; reject a double free or a full stack, else push the id.
            if (slot_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               if (id_free || total_ff >= NUM_TOTAL) begin
                  emit_status = ST_DOUBLE;
               end else begin
                  emit_status = ST_DONE;
                  map_we      = 1'b1;
                  stk_we      = 1'b1;
                  total_in    = total_ff + TOTAL_W'(1);
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Response register: load on a new result, drop after its transfer.
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_id_in     = emit_id;
         rsp_status_in = emit_status;
         rsp_last_in   = emit_last;
         rsp_count_in  = total_in;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= NUM_TOTAL;
         low_ff       <= NUM_TOTAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         low_ff       <= low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      remain_ff     <= remain_in;
      fid_ff        <= fid_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_granted_id = rsp_id_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_free_count = rsp_count_ff;

endmodule

[rtl/bfla_checker.sv]
// Port-level assertions for the block free list allocator, bound to the top.
// Depends on bfla_pkg for widths and status codes.
module bfla_checker
   import bfla_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_cmd,
   input logic [COUNT_W-1:0] req_count,
   input logic [ID_W-1:0]    req_free_id,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [ID_W-1:0]    rsp_granted_id,
   input logic [2:0]         rsp_status,
   input logic               rsp_last,
   input logic [TOTAL_W-1:0] rsp_free_count
);

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted_id) &&
         $stable(rsp_status) && $stable(rsp_last) && $stable(rsp_free_count))
      else $error("response changed while stalled");

   // The free count never exceeds the pool size.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_free_count <= TOTAL_W'(NUM_BLOCKS))
      else $error("free count above pool size");

   // Only a grant carries an id; every other result ends its request.
   a_nongrant_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_GRANTED |-> rsp_granted_id == '0 && rsp_last)
      else $error("non-grant result with id or without last");

   // Each grant that is taken lowers the free count by one at the next one.
   a_grant_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_status == ST_GRANTED && !rsp_last |=>
         !rsp_valid || (rsp_status == ST_GRANTED &&
                        rsp_free_count == $past(rsp_free_count) - TOTAL_W'(1)))
      else $error("grant burst broken");

endmodule

bind block_free_list_allocator bfla_checker u_bfla_checker (.*);
